@@ rtl/core/epsa_pkg.sv @@
// Shared constants, command codes and controller/datapath interface types
// for the encoder position, speed and acceleration unit. No dependencies.
package epsa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  // Dividend width: magnitude of a word difference shifted by the fraction.
  localparam int NUM_W     = WORD_BITS + 1 + FRAC_BITS;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int POS_W     = WORD_BITS + 3;
  localparam int SS_W      = WORD_BITS - 1;

  localparam logic [1:0] CMD_POS   = 2'd0;
  localparam logic [1:0] CMD_SPEED = 2'd1;
  localparam logic [1:0] CMD_ACCEL = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [1:0] REG_MIN_POS   = 2'd1;
  localparam logic [1:0] REG_MAX_POS   = 2'd2;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_DIV_AM,
    DP_TAKE_AM,
    DP_MM_DBL,
    DP_MM_ADD,
    DP_SIGN,
    DP_DIV_WRAP,
    DP_TAKE_WRAP,
    DP_FIX,
    DP_SAT,
    DP_ERR,
    DP_DIV_SPD,
    DP_TAKE_SPD,
    DP_DIV_ACC,
    DP_TAKE_ACC,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       skip;
    logic       mm_last;
    logic       below_min;
    logic       div_done;
    logic       ivl_zero;
  } dp_stat_t;

endpackage

@@ rtl/core/epsa_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, with a saturating
// quotient and the remainder. Depends on epsa_pkg.
module epsa_div
  import epsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [WORD_BITS-1:0] den,
  input  logic [CNT_W-1:0]     iters,
  output logic                 done,
  output logic [WORD_BITS:0]   quo,
  output logic [WORD_BITS-1:0] rem
);

  localparam logic [WORD_BITS+1:0] QSAT =
    ((WORD_BITS+2)'(1) << (WORD_BITS - 1)) + (WORD_BITS+2)'(1);
  localparam logic [WORD_BITS+1:0] HALF = (WORD_BITS+2)'(1) << (WORD_BITS - 1);

  logic [NUM_W-1:0]     num_r;
  logic [WORD_BITS-1:0] den_r, rem_r;
  logic [WORD_BITS:0]   q_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;

  logic [WORD_BITS:0]   trial;
  logic                 ge;
  logic [WORD_BITS+1:0] qt;

  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    ge    = trial >= {1'b0, den_r};
    qt    = {q_r, ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        rem_r <= ge ? WORD_BITS'(trial - {1'b0, den_r}) : trial[WORD_BITS-1:0];
        // Once the quotient passes the saturation point it stays pinned there.
        q_r   <= (qt > HALF) ? QSAT[WORD_BITS:0] : qt[WORD_BITS:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/epsa_dp.sv @@
// Datapath: configuration registers, modular scaling, wrap, stored state,
// the shared divider and the output register. Depends on epsa_pkg, epsa_div.
module epsa_dp
  import epsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic [1:0]           in_cmd,
  input  logic signed [31:0]   in_steps,
  input  logic [31:0]          in_interval,
  input  dp_cmd_t              dcmd,
  output dp_stat_t             dstat,
  output logic signed [31:0]   out_position,
  output logic signed [31:0]   out_speed,
  output logic signed [31:0]   out_accel,
  output logic                 out_status
);

  localparam logic signed [POS_W-1:0] WMAX = POS_W'((64'(1) << (WORD_BITS - 1)) - 1);
  localparam logic signed [POS_W-1:0] WMIN = -POS_W'(64'(1) << (WORD_BITS - 1));

  logic [SS_W-1:0]             step_size_r;
  logic signed [WORD_BITS-1:0] min_r, max_r;
  logic [1:0]                  cmd_r;
  logic                        neg_r, dneg_r;
  logic [WORD_BITS-1:0]        mag_r, ivl_r, range_r, am_r, res_r;
  logic [4:0]                  bit_r;
  logic signed [POS_W-1:0]     pos_r;
  logic signed [WORD_BITS-1:0] speed_r, accel_r, lastp_r, lasts_r;
  logic                        err_r;

  logic signed [WORD_BITS:0]   span;
  logic [WORD_BITS:0]          t_dbl, t_add;
  logic [WORD_BITS-1:0]        dbl_red, add_red;
  logic signed [POS_W-1:0]     min_x, max_x, d_wrap, rng_x;
  logic signed [WORD_BITS:0]   diff;
  logic [WORD_BITS:0]          diff_mag;
  logic signed [WORD_BITS-1:0] qsig;

  logic                 div_start, div_done;
  logic [NUM_W-1:0]     div_num;
  logic [WORD_BITS-1:0] div_den;
  logic [CNT_W-1:0]     div_iters;
  logic [WORD_BITS:0]   div_quo;
  logic [WORD_BITS-1:0] div_rem;

  always_comb begin
    span    = {max_r[WORD_BITS-1], max_r} - {min_r[WORD_BITS-1], min_r};
    min_x   = POS_W'(min_r);
    max_x   = POS_W'(max_r);
    rng_x   = POS_W'({1'b0, range_r});
    t_dbl   = {res_r, 1'b0};
    dbl_red = (t_dbl >= {1'b0, range_r}) ? WORD_BITS'(t_dbl - {1'b0, range_r})
                                         : t_dbl[WORD_BITS-1:0];
    t_add   = {1'b0, res_r} + {1'b0, am_r};
    add_red = (t_add >= {1'b0, range_r}) ? WORD_BITS'(t_add - {1'b0, range_r})
                                         : t_add[WORD_BITS-1:0];
    d_wrap  = min_x - pos_r;
    if (dcmd.op == DP_DIV_ACC) begin
      diff = {speed_r[WORD_BITS-1], speed_r} - {lasts_r[WORD_BITS-1], lasts_r};
    end else begin
      diff = {pos_r[WORD_BITS-1], pos_r[WORD_BITS-1:0]}
             - {lastp_r[WORD_BITS-1], lastp_r};
    end
    diff_mag = diff[WORD_BITS] ? (WORD_BITS+1)'(-diff) : diff;
    if (dneg_r) begin
      qsig = (div_quo > (WORD_BITS+1)'(64'(1) << (WORD_BITS - 1)))
             ? WORD_BITS'(64'(1) << (WORD_BITS - 1))
             : WORD_BITS'(-div_quo);
    end else begin
      qsig = (div_quo > (WORD_BITS+1)'((64'(1) << (WORD_BITS - 1)) - 1))
             ? WORD_BITS'((64'(1) << (WORD_BITS - 1)) - 1)
             : div_quo[WORD_BITS-1:0];
    end
  end

  // Divider operand selection per operation.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = range_r;
    div_iters = CNT_W'(SS_W);
    case (dcmd.op)
      DP_DIV_AM: begin
        div_start = 1'b1;
        div_num   = {step_size_r, (NUM_W-SS_W)'(0)};
      end
      DP_DIV_WRAP: begin
        div_start = 1'b1;
        div_num   = {d_wrap[WORD_BITS+1:0], (NUM_W-WORD_BITS-2)'(0)};
        div_iters = CNT_W'(WORD_BITS + 2);
      end
      DP_DIV_SPD, DP_DIV_ACC: begin
        div_start = 1'b1;
        div_num   = {diff_mag, (NUM_W-WORD_BITS-1)'(0)};
        div_den   = ivl_r;
        div_iters = CNT_W'(NUM_W);
      end
      default: ;
    endcase
  end

  epsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= SS_W'(65536);
      min_r       <= '0;
      max_r       <= WORD_BITS'(23592960);
      lastp_r     <= '0;
      lasts_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP_SIZE: step_size_r <= cfg_wdata[SS_W-1:0];
          REG_MIN_POS:   min_r       <= cfg_wdata;
          REG_MAX_POS:   max_r       <= cfg_wdata;
          default: ;
        endcase
      end
      case (dcmd.op)
        DP_LOAD: begin
          cmd_r   <= in_cmd;
          neg_r   <= in_steps[WORD_BITS-1];
          mag_r   <= in_steps[WORD_BITS-1] ? WORD_BITS'(-in_steps) : in_steps;
          ivl_r   <= in_interval;
          range_r <= span[WORD_BITS] ? WORD_BITS'(-span) : span[WORD_BITS-1:0];
          pos_r   <= '0;
          speed_r <= '0;
          accel_r <= '0;
          err_r   <= 1'b0;
        end
        DP_CLEAR: begin
          lastp_r <= '0;
          lasts_r <= '0;
        end
        DP_TAKE_AM: begin
          am_r  <= div_rem;
          res_r <= '0;
          bit_r <= 5'd31;
        end
        DP_MM_DBL: res_r <= dbl_red;
        DP_MM_ADD: begin
          if (mag_r[bit_r]) begin
            res_r <= add_red;
          end
          bit_r <= bit_r - 1'b1;
        end
        DP_SIGN: pos_r <= neg_r ? -POS_W'(res_r) : POS_W'(res_r);
        DP_DIV_WRAP: ;
        DP_TAKE_WRAP: begin
          pos_r <= (div_rem == '0) ? min_x : POS_W'(min_x + rng_x - POS_W'(div_rem));
        end
        DP_FIX: begin
          if (pos_r >= max_x) begin
            pos_r <= pos_r - rng_x;
          end
        end
        DP_SAT: begin
          if (pos_r > WMAX) begin
            pos_r <= WMAX;
          end else if (pos_r < WMIN) begin
            pos_r <= WMIN;
          end
        end
        DP_ERR: err_r <= 1'b1;
        DP_DIV_SPD, DP_DIV_ACC: dneg_r <= diff[WORD_BITS];
        DP_TAKE_SPD: begin
          speed_r <= qsig;
          lastp_r <= pos_r[WORD_BITS-1:0];
        end
        DP_TAKE_ACC: begin
          accel_r <= qsig;
          lasts_r <= speed_r;
        end
        DP_OUT: begin
          out_position <= pos_r[WORD_BITS-1:0];
          out_speed    <= speed_r;
          out_accel    <= accel_r;
          out_status   <= err_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    dstat.cmd       = cmd_r;
    dstat.skip      = (step_size_r == '0) || (range_r == '0);
    dstat.mm_last   = (bit_r == 5'd0);
    dstat.below_min = pos_r < min_x;
    dstat.div_done  = div_done;
    dstat.ivl_zero  = (ivl_r == '0);
  end

endmodule

@@ rtl/core/epsa_ctrl.sv @@
// Controller state machine: sequences datapath operations for one request
// and owns the input and output handshakes. Depends on epsa_pkg.
module epsa_ctrl
  import epsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t dstat,
  output dp_cmd_t  dcmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_AMW, S_MMD, S_MMA, S_SIGN, S_WRAP, S_WRAPW,
    S_FIX, S_SAT, S_POST, S_SPDW, S_ACCS, S_ACCW, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    dcmd.op       = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.op   = DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (dstat.cmd == CMD_CLEAR) begin
          dcmd.op   = DP_CLEAR;
          state_nxt = S_OUT;
        end else if (dstat.skip) begin
          state_nxt = S_POST;
        end else begin
          dcmd.op   = DP_DIV_AM;
          state_nxt = S_AMW;
        end
      end
      S_AMW: begin
        if (dstat.div_done) begin
          dcmd.op   = DP_TAKE_AM;
          state_nxt = S_MMD;
        end
      end
      S_MMD: begin
        dcmd.op   = DP_MM_DBL;
        state_nxt = S_MMA;
      end
      S_MMA: begin
        dcmd.op   = DP_MM_ADD;
        state_nxt = dstat.mm_last ? S_SIGN : S_MMD;
      end
      S_SIGN: begin
        dcmd.op   = DP_SIGN;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (dstat.below_min) begin
          dcmd.op   = DP_DIV_WRAP;
          state_nxt = S_WRAPW;
        end else begin
          state_nxt = S_FIX;
        end
      end
      S_WRAPW: begin
        if (dstat.div_done) begin
          dcmd.op   = DP_TAKE_WRAP;
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        dcmd.op   = DP_FIX;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        dcmd.op   = DP_SAT;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (dstat.cmd == CMD_POS) begin
          state_nxt = S_OUT;
        end else if (dstat.ivl_zero) begin
          dcmd.op   = DP_ERR;
          state_nxt = S_OUT;
        end else begin
          dcmd.op   = DP_DIV_SPD;
          state_nxt = S_SPDW;
        end
      end
      S_SPDW: begin
        if (dstat.div_done) begin
          dcmd.op   = DP_TAKE_SPD;
          state_nxt = (dstat.cmd == CMD_ACCEL) ? S_ACCS : S_OUT;
        end
      end
      S_ACCS: begin
        dcmd.op   = DP_DIV_ACC;
        state_nxt = S_ACCW;
      end
      S_ACCW: begin
        if (dstat.div_done) begin
          dcmd.op   = DP_TAKE_ACC;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          dcmd.op       = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/encoder_position_speed_accel_unit.sv @@
// Top level of the encoder position, speed and acceleration unit.
// Depends on epsa_pkg, epsa_ctrl and epsa_dp (which holds epsa_div).
//
// Usage: a request on the in_ channel carries a command, a signed encoder
// step count and a Q16.16 sample interval. The unit scales the count by
// step_size, wraps it into the range set by min_pos and max_pos, and for
// speed and acceleration commands divides the differences against the
// stored previous position and speed by the interval. Exactly one result
// request leaves on the out_ channel for every accepted input request.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
//
// Timing: one request is processed at a time. The work is serialized on
// one shared restoring divider (one bit per cycle) plus a modular
// multiply loop of a doubling step and an add step per step bit. A
// clear command skips the arithmetic; a position command uses the
// divider once, a speed command twice and an acceleration command three
// times, plus one wrap reduction when the scaled position lies below min_pos.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the stored position and speed. The result sits in an output register, so
// a new request is accepted while the previous result waits; if the
// receiver stalls, the unit finishes the next request and then holds it
// until the output register frees up.
module encoder_position_speed_accel_unit
  import epsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_steps,
  input  logic [31:0]        in_interval,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_speed,
  output logic signed [31:0] out_accel,
  output logic               out_status
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // Sequencer: decides the next datapath operation from the status flags.
  epsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dstat     (dstat),
    .dcmd      (dcmd)
  );

  // Arithmetic, stored state, configuration and the output register.
  epsa_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_cmd       (in_cmd),
    .in_steps     (in_steps),
    .in_interval  (in_interval),
    .dcmd         (dcmd),
    .dstat        (dstat),
    .out_position (out_position),
    .out_speed    (out_speed),
    .out_accel    (out_accel),
    .out_status   (out_status)
  );

endmodule
